/* sv/fdb4_pkg.sv */
// ----------------------------------------------------------------------------
// fdb4_pkg
// Shared constants, types and the coefficient table of the decimating FIR.
// ----------------------------------------------------------------------------
package fdb4_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAPS       = 256;
    localparam int COEF_WIDTH = 18;
    localparam int DECIM      = 4;
    localparam int PHASE_W    = $clog2(DECIM);

    localparam int HIST_DEPTH = TAPS - 1;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int K_W        = $clog2(TAPS + 1);

    localparam int PROD_W     = SAMPLE_W + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int OUT_SHIFT  = COEF_WIDTH - 1;

    // Stored table is Q1.17 over the first half of the symmetric prototype.
    localparam int ROM_HALF   = 128;
    localparam int ROM_AW     = $clog2(ROM_HALF);
    localparam int ROM_W      = 18;
    localparam int ROM_SHL    = (COEF_WIDTH >= ROM_W) ? COEF_WIDTH - ROM_W : 0;
    localparam int ROM_SHR    = (COEF_WIDTH <  ROM_W) ? ROM_W - COEF_WIDTH : 0;

    typedef logic signed [ROM_W-1:0] t_rom_word;

    localparam t_rom_word HALF_ROM [ROM_HALF] = '{
        -18'sd3, -18'sd2, 18'sd0, 18'sd3, 18'sd5, 18'sd5, 18'sd2, -18'sd3,
        -18'sd8, -18'sd9, -18'sd5, 18'sd2, 18'sd10, 18'sd14, 18'sd11, 18'sd1,
        -18'sd12, -18'sd20, -18'sd19, -18'sd7, 18'sd11, 18'sd25, 18'sd28, 18'sd16,
        -18'sd7, -18'sd30, -18'sd40, -18'sd29, -18'sd1, 18'sd31, 18'sd51, 18'sd46,
        18'sd15, -18'sd28, -18'sd61, -18'sd66, -18'sd36, 18'sd18, 18'sd68, 18'sd88,
        18'sd63, 18'sd1, -18'sd68, -18'sd109, -18'sd95, -18'sd30, 18'sd59, 18'sd126,
        18'sd132, 18'sd69, -18'sd38, -18'sd135, -18'sd170, -18'sd118, 18'sd2, 18'sd133,
        18'sd206, 18'sd177, 18'sd51, -18'sd114, -18'sd233, -18'sd240, -18'sd120, 18'sd74,
        18'sd247, 18'sd304, 18'sd206, -18'sd10, -18'sd239, -18'sd362, -18'sd304, -18'sd81,
        18'sd204, 18'sd406, 18'sd411, 18'sd199, -18'sd136, -18'sd427, -18'sd517, -18'sd342,
        18'sd28, 18'sd414, 18'sd614, 18'sd507, 18'sd124, -18'sd357, -18'sd689, -18'sd687,
        -18'sd321, 18'sd245, 18'sd730, 18'sd871, 18'sd565, -18'sd66, -18'sd719, -18'sd1049,
        -18'sd855, -18'sd191, 18'sd637, 18'sd1205, 18'sd1189, 18'sd540, -18'sd461, -18'sd1319,
        -18'sd1566, -18'sd1004, 18'sd157, 18'sd1368, 18'sd1991, 18'sd1622,
        18'sd330, -18'sd1315, -18'sd2483, -18'sd2477, -18'sd1116, 18'sd1092, 18'sd3105,
        18'sd3794, 18'sd2504, -18'sd522, -18'sd4079, -18'sd6368, -18'sd5687, -18'sd1176,
        18'sd6704, 18'sd16170, 18'sd24647, 18'sd29647
    };

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [SAMPLE_W-1:0]   t_sample;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_RND  = 4'b0100,
        S_SAT  = 4'b1000
    } t_state;

    // Coefficient of tap k: mirror the half table, zero past its end,
    // rescale to COEF_WIDTH with round-half-away-from-zero when narrowing.
    function automatic t_coef coef_at(input logic [K_W-1:0] k);
        logic [K_W-1:0]       m;
        logic signed [31:0]   c;
        logic [31:0]          mag;
        logic [31:0]          q;
        m = K_W'(2 * ROM_HALF - 1) - k;
        if (k < K_W'(ROM_HALF)) begin
            c = 32'(HALF_ROM[k[ROM_AW-1:0]]);
        end else if (k < K_W'(2 * ROM_HALF)) begin
            c = 32'(HALF_ROM[m[ROM_AW-1:0]]);
        end else begin
            c = '0;
        end
        if (COEF_WIDTH >= ROM_W) begin
            c = c <<< ROM_SHL;
        end else begin
            mag = c[31] ? 32'(-c) : 32'(c);
            q   = (mag + ((32'd1 << ROM_SHR) >> 1)) >> ROM_SHR;
            c   = c[31] ? -$signed(q) : $signed(q);
        end
        return c[COEF_WIDTH-1:0];
    endfunction

endpackage

/* sv/fdb4_ram.sv */
// ----------------------------------------------------------------------------
// fdb4_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fdb4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fir_decimate_by_four.sv */
// ----------------------------------------------------------------------------
// fir_decimate_by_four
// 256-tap symmetric low-pass FIR with decimation by four, one shared MAC.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit word per input handshake and returns one filtered
// word for every fourth input, starting with the first input after reset. The
// last 255 samples live in a circular buffer in a single RAM; a fill count
// makes never-written entries read as zero, so reset needs no clearing pass.
// An off-phase input is written into the buffer in its accept cycle and the
// input is ready again on the next cycle. An on-phase input walks the buffer
// through the RAM read port, one tap per cycle into a 16x18 multiplier and a
// 42-bit accumulator; then the read and multiply stages drain, and a round
// step and a saturate step follow. An on-phase word holds the input from its
// accept cycle until the saturate step is done. The result sits in an output
// register, so the next inputs are taken while it waits to be read; a new
// result waits in the saturate step, holding the input for as long, only if
// the previous one has still not been taken.
module fir_decimate_by_four
    import fdb4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_sample_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_sample_out
);

    // Control state
    t_state               r_state;
    logic [PHASE_W-1:0]   r_phase;
    logic [HA_W-1:0]      r_wp;       // slot of the oldest sample, next to overwrite
    logic [HA_W-1:0]      r_rd_ptr;
    logic [FILL_W-1:0]    r_fill;     // entries written since reset, saturating
    logic [K_W-1:0]       r_k;        // tap being issued
    logic                 r_s1_vld;
    logic                 r_s2_vld;
    logic                 r_out_valid;

    // Datapath
    t_sample              r_x;
    t_coef                r_s1_coef;
    logic                 r_s1_is_x;
    logic                 r_s1_hv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                 r_neg;
    logic [ACC_W-1:0]     r_mag;
    t_sample              r_out;

    logic                 in_acc;
    logic                 out_acc;
    logic                 issue;
    logic                 ram_we;
    logic [HA_W-1:0]      ram_waddr;
    t_sample              ram_wdata;
    t_sample              ram_rdata;
    t_sample              opnd;
    logic [K_W:0]         age_sum;
    logic                 hist_valid;
    logic [ACC_W:0]       q;
    logic [ACC_W:0]       q_neg;
    t_sample              n_out;
    logic                 sat_go;
    logic [HA_W-1:0]      n_wp;
    logic [HA_W-1:0]      n_rd_ptr;
    logic [FILL_W-1:0]    n_fill;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;
    assign issue   = (r_state == S_MAC) && (r_k < K_W'(TAPS));
    assign sat_go  = (r_state == S_SAT) && (!r_out_valid || i_out_ready);

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // Advance circular pointers with wrap at the buffer depth
    assign n_wp     = (r_wp == HA_W'(HIST_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == HA_W'(HIST_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign n_fill   = (r_fill == FILL_W'(HIST_DEPTH)) ? r_fill : r_fill + 1'b1;

    // Write the new sample over the oldest one: off-phase at accept,
    // on-phase once every history read has been issued.
    assign ram_we    = (in_acc && (r_phase != '0)) || (r_state == S_RND);
    assign ram_waddr = r_wp;
    assign ram_wdata = (r_state == S_RND) ? r_x : i_sample_in;

    fdb4_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Tap k maps to history index k; index k was written iff k >= depth - fill
    assign age_sum    = (K_W + 1)'(r_k) + (K_W + 1)'(r_fill);
    assign hist_valid = (age_sum >= (K_W + 1)'(HIST_DEPTH));

    // Last tap takes the incoming sample instead of the RAM
    assign opnd = r_s1_is_x ? r_x : (r_s1_hv ? ram_rdata : '0);

    // Round half away from zero on the magnitude, then saturate
    assign q     = ({1'b0, r_mag} + (ACC_W + 1)'(1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    assign q_neg = '0 - q;

    always_comb begin
        if (r_neg) begin
            n_out = (q > (ACC_W + 1)'(32768)) ? 16'sh8000 : q_neg[SAMPLE_W-1:0];
        end else begin
            n_out = (q > (ACC_W + 1)'(32767)) ? 16'sh7fff : q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_wp        <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            // Load a new result, or drop the flag once the word is taken
            if (sat_go) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase <= r_phase + 1'b1;
                        if (r_phase == '0) begin
                            r_state  <= S_MAC;
                            r_k      <= '0;
                            r_rd_ptr <= r_wp;
                        end else begin
                            r_wp   <= n_wp;
                            r_fill <= n_fill;
                        end
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        r_k      <= r_k + 1'b1;
                        r_rd_ptr <= n_rd_ptr;
                    end else if (!r_s1_vld && !r_s2_vld) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_wp    <= n_wp;
                    r_fill  <= n_fill;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (sat_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= i_sample_in;
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        r_s1_coef <= coef_at(r_k);
        r_s1_is_x <= (r_k == K_W'(TAPS - 1));
        r_s1_hv   <= hist_valid;
        r_prod    <= PROD_W'(opnd) * PROD_W'(r_s1_coef);
        if (r_state == S_RND) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end
        if (sat_go) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_no_write_during_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> !ram_we)
        else $error("history written while taps are being read");

    a_phase0_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == '0)) |=> (r_state == S_MAC))
        else $error("on-phase word did not start a filter pass");

    a_result_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_SAT))
        else $error("result appeared outside the saturate step");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("fill count past buffer depth");
`endif

endmodule

/* verif/tb_fir_decimate_by_four.sv */
// ----------------------------------------------------------------------------
// tb_fir_decimate_by_four
// Self-checking bench for the decimate-by-four 256-tap low-pass FIR.
// ----------------------------------------------------------------------------
// Drives 16-bit sample words through the valid/ready input channel. Every
// accepted word goes through a bit-exact filter predictor, which queues one
// expected output word per group of four inputs. A monitor compares each
// output word with the oldest queued word. Stimulus starts with a short
// directed part (rounding ties, full-scale extremes) and then moves to random
// bursts of noise, DC, quiet, alternating full-scale and coefficient-matched
// windows that drive the output into saturation, under three idling regimes.
// ----------------------------------------------------------------------------
module tb_fir_decimate_by_four
    import fdb4_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 9;
    // One on-phase word keeps the MAC busy for a whole filter pass; allow
    // plenty of margin on top of that and of receiver and sender stalls.
    localparam int WATCHDOG_LIMIT = 16 * (TAPS + 8);
    localparam int TAIL_CYCLES    = 2 * (TAPS + 8);
    localparam int ROM_Q          = 17;

    typedef enum int {
        BURST_NOISE,
        BURST_DC,
        BURST_QUIET,
        BURST_NYQUIST,
        BURST_MATCHED
    } t_burst;

    logic    i_clk        = 1'b0;
    logic    i_rst_n      = 1'b0;
    logic    i_in_valid   = 1'b0;
    logic    o_in_ready;
    t_sample i_sample_in  = '0;
    logic    o_out_valid;
    logic    i_out_ready  = 1'b0;
    t_sample o_sample_out;

    // Predictor state: history oldest first, phase within the group of four.
    t_sample             hist_words [HIST_DEPTH];
    logic [PHASE_W-1:0]  group_phase;
    t_sample             pending_outputs [$];

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int words_sent   = 0;
    int err_count    = 0;
    int quiet_cycles = 0;

    fir_decimate_by_four uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Filter predictor
    // ------------------------------------------------------------------------

    // Tap weight at the block's coefficient width: mirror the Q1.17 half
    // table, zero past its end, round half away from zero when narrowing.
    function automatic longint tap_weight(input int k);
        longint c;
        longint mag;
        int     sh;
        if (k < ROM_HALF) begin
            c = HALF_ROM[k];
        end else if (k < 2 * ROM_HALF) begin
            c = HALF_ROM[2 * ROM_HALF - 1 - k];
        end else begin
            c = 0;
        end
        if (COEF_WIDTH >= ROM_Q + 1) begin
            return c <<< (COEF_WIDTH - ROM_Q - 1);
        end
        sh  = ROM_Q + 1 - COEF_WIDTH;
        mag = (c < 0) ? -c : c;
        mag = (mag + ((64'sd1 <<< sh) >>> 1)) >>> sh;
        return (c < 0) ? -mag : mag;
    endfunction

    // Advance the predictor by one accepted word; on phase 0 queue the
    // rounded and saturated FIR output over the newest TAPS samples.
    task automatic filter_model_word(input t_sample x);
        longint  acc;
        longint  mag;
        longint  q;
        t_sample y;
        if (group_phase == '0) begin
            acc = 0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                acc += tap_weight(k) * longint'(hist_words[k]);
            end
            acc += tap_weight(TAPS - 1) * longint'(x);
            mag = (acc < 0) ? -acc : acc;
            q   = (mag + (64'sd1 <<< (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
            if (acc < 0) begin
                y = (q > 32768) ? t_sample'(-32768) : t_sample'(-q);
            end else begin
                y = (q > 32767) ? t_sample'(32767) : t_sample'(q);
            end
            pending_outputs.push_back(y);
        end
        for (int k = 0; k + 1 < HIST_DEPTH; k++) begin
            hist_words[k] = hist_words[k + 1];
        end
        hist_words[HIST_DEPTH - 1] = x;
        group_phase = group_phase + 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted. Valid stays high between
    // back-to-back words; drop it only when an idle gap is chosen, so that
    // valid never gets two updates in the same step.
    task automatic send_word(input t_sample x);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        // Outputs and our own drives are read before the edge updates them.
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        filter_model_word(x);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: receiver stalls, result check and watchdog
    // ------------------------------------------------------------------------

    // Stall the receiver at random, one update per cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: sample_out expected none, actual %0d",
                         $time, o_sample_out);
                err_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out expected %0d, actual %0d",
                             $time, want, o_sample_out);
                    err_count++;
                end
            end
        end
    end

    // End the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d outputs outstanding",
                         $time, WATCHDOG_LIMIT, pending_outputs.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hold reset, then release it with the predictor at its reset state.
    task automatic apply_reset();
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_words[k] = '0;
        end
        group_phase = '0;
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // With a cleared history, place single samples so that the sums land
    // exactly halfway between two outputs, once positive and once negative.
    // The first word after reset must produce an output on its own.
    task automatic test_rounding_ties();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_word(16'sd0);
        send_word(16'sd0);
        send_word(16'sd0);
        // Previous tap weighs -2: -2 * -32768 = +0.5 LSB after the shift.
        send_word(-16'sd32768);
        send_word(16'sd0);
        send_word(16'sd0);
        send_word(16'sd0);
        // -2 * 16384 plus the older sample at weight 5 gives -1.5 LSB.
        send_word(16'sd16384);
        send_word(16'sd0);
    endtask

    // Walk the input through its extremes and alternating bit patterns.
    task automatic test_input_extremes();
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(-16'sd1);
        send_word(16'sd1);
        send_word(16'sh5555);
        send_word(-16'sh5556);
        send_word(16'sd32767);
        send_word(16'sd32767);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(-16'sd32768);
        send_word(-16'sd32768);
        send_word(16'sd0);
        send_word(-16'sd1);
        send_word(16'sh7ffe);
    endtask

    // Random bursts under one idling regime. Matched bursts line up a full
    // window with the coefficient signs so the output hits either rail.
    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int n_words);
        int      first_word;
        int      pick;
        int      len;
        int      mag;
        bit      go_high;
        longint  w;
        t_sample level;
        t_burst  kind;
        in_idle_pct  = src_pct;
        out_idle_pct = snk_pct;
        first_word   = words_sent;
        while (words_sent - first_word < n_words) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                kind = BURST_NOISE;
            end else if (pick < 55) begin
                kind = BURST_DC;
            end else if (pick < 70) begin
                kind = BURST_QUIET;
            end else if (pick < 85) begin
                kind = BURST_NYQUIST;
            end else begin
                kind = BURST_MATCHED;
            end
            len     = $urandom_range(64, 4);
            go_high = $urandom_range(1);
            level   = t_sample'($urandom);
            case (kind)
                BURST_NOISE: begin
                    repeat (len) send_word(t_sample'($urandom));
                end
                BURST_DC: begin
                    repeat (len) send_word(level);
                end
                BURST_QUIET: begin
                    repeat (len) send_word(t_sample'($urandom_range(31)) - 16'sd16);
                end
                BURST_NYQUIST: begin
                    repeat (len) begin
                        send_word(go_high ? 16'sd32767 : -16'sd32768);
                        go_high = !go_high;
                    end
                end
                BURST_MATCHED: begin
                    // Pad so the last word of the window falls on phase 0.
                    while (((words_sent + TAPS - 1) % DECIM) != 0) begin
                        send_word(t_sample'($urandom));
                    end
                    for (int k = 0; k < TAPS; k++) begin
                        w   = tap_weight(k);
                        mag = $urandom_range(32767, 28000);
                        if (w == 0) begin
                            send_word(t_sample'($urandom));
                        end else if ((w > 0) == go_high) begin
                            send_word(t_sample'(mag));
                        end else begin
                            send_word(t_sample'(-mag - 1));
                        end
                    end
                end
                default: begin
                    send_word(level);
                end
            endcase
        end
    endtask

    // Stop offering words, then wait for every expected output and a tail.
    task automatic test_drain();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        apply_reset();
        test_rounding_ties();
        test_input_extremes();
        test_random_traffic(35, 45, 360);
        test_random_traffic(45, 35, 360);
        test_random_traffic(0, 0, 360);
        test_drain();
        if (err_count == 0 && pending_outputs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/fdb4_pkg.sv
sv/fdb4_ram.sv
sv/fir_decimate_by_four.sv
verif/tb_fir_decimate_by_four.sv
